/* rtl/core/touch_key_scan_average_threshold_defines.svh */
// assertion macros for the touch key scanner
// no dependencies; included by the files that carry assertions
`ifndef TOUCH_KEY_SCAN_AVERAGE_THRESHOLD_DEFINES_SVH
`define TOUCH_KEY_SCAN_AVERAGE_THRESHOLD_DEFINES_SVH

`ifndef SYNTH

`define TKS_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("touch key scanner check failed");

`define TKS_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("touch key scanner check failed");

`else

`define TKS_ASSERT_IMP(lbl, clk, rst, ante, cons)

`define TKS_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

/* rtl/core/tks_pkg.sv */
// types, register indexes and default sizes for the touch key scanner
// no dependencies
package tks_pkg;

   localparam int KEYS_DEF       = 4;
   localparam int WINDOW_DEF     = 8;
   localparam int COUNT_BITS_DEF = 14;

   localparam int SAMPLE_W   = 14;
   localparam int KEY_W      = 2;
   localparam int MASK_W     = 4;
   localparam int NUMB_W     = 3;
   localparam int DISCH_W    = 8;
   localparam int THR_W      = 14;
   localparam int THR_REGS   = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 14;

   localparam logic [CSR_IDX_W-1:0] CSR_NUM_BUTTONS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DISCHARGE_MS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_KEY0 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_KEY1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_KEY2 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_KEY3 = 3'd5;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   typedef struct packed {
      logic                command;
      logic [SAMPLE_W-1:0] sample;
   } req_beat_type;

   typedef struct packed {
      logic                accepted;
      logic [KEY_W-1:0]    key_index;
      logic [SAMPLE_W-1:0] raw_count;
      logic [SAMPLE_W-1:0] smooth_count;
      logic [MASK_W-1:0]   touched_mask;
      logic                hold_active;
      logic [KEY_W-1:0]    next_key;
   } rsp_beat_type;

endpackage

/* rtl/core/tks_ram.sv */
// generic single write port, single read port ram with registered read
// no dependencies
module tks_ram #(
   parameter int WIDTH = 14,
   parameter int DEPTH = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/touch_key_scan_average_threshold.sv */
// touch key scanner: round robin keys, moving average window, touch threshold
// depends on tks_pkg, tks_ram and touch_key_scan_average_threshold_defines.svh
// a result beat is registered in stage 1, stage 2 and then the result register after its request beat is taken
// throughput: one beat per cycle when rsp_ready does not stall the three register stage pipeline
// window ram read, running total update, then reciprocal divide and compare
// reset: synchronous, config to defaults, clears scan pointer, hold, totals and fill flags
`include "touch_key_scan_average_threshold_defines.svh"

module touch_key_scan_average_threshold #(
   parameter int KEYS       = tks_pkg::KEYS_DEF,
   parameter int WINDOW     = tks_pkg::WINDOW_DEF,
   parameter int COUNT_BITS = tks_pkg::COUNT_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  tks_pkg::req_beat_type              req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output tks_pkg::rsp_beat_type              rsp_data,
   input  logic                               csr_we,
   input  logic [tks_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tks_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import tks_pkg::*;

   localparam int KEY_BITS  = (KEYS > 1) ? $clog2(KEYS) : 1;
   localparam int POS_BITS  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int ADDR_BITS = KEY_BITS + POS_BITS;
   localparam int TOT_W     = COUNT_BITS + POS_BITS;
   localparam int ACT_W     = ($clog2(KEYS + 1) > NUMB_W) ? $clog2(KEYS + 1) : NUMB_W;
   localparam int SHIFT     = TOT_W + POS_BITS;
   localparam int RECIP_W   = SHIFT + 1;
   localparam int PROD_W    = TOT_W + RECIP_W;
   localparam int CMP_W     = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;
   localparam longint unsigned RECIP = ((64'd1 << SHIFT) + WINDOW - 1) / WINDOW;

   // configuration
   logic [NUMB_W-1:0]  num_buttons_ff;
   logic [DISCH_W-1:0] discharge_ms_ff;
   logic [THR_W-1:0]   threshold_ff [THR_REGS];

   always_ff @(posedge clock) begin
      if (reset) begin
         num_buttons_ff  <= NUMB_W'(1);
         discharge_ms_ff <= '0;
         for (int i = 0; i < THR_REGS; i++) begin
            threshold_ff[i] <= '0;
         end
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NUM_BUTTONS:    num_buttons_ff  <= csr_wdata[NUMB_W-1:0];
            CSR_DISCHARGE_MS:   discharge_ms_ff <= csr_wdata[DISCH_W-1:0];
            CSR_THRESHOLD_KEY0: threshold_ff[0] <= csr_wdata[THR_W-1:0];
            CSR_THRESHOLD_KEY1: threshold_ff[1] <= csr_wdata[THR_W-1:0];
            CSR_THRESHOLD_KEY2: threshold_ff[2] <= csr_wdata[THR_W-1:0];
            CSR_THRESHOLD_KEY3: threshold_ff[3] <= csr_wdata[THR_W-1:0];
            default: ;
         endcase
      end
   end

   // pipeline handshake
   logic s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic s1_valid_in, s2_valid_in, rsp_valid_in;
   logic rsp_load, s2_ready, s1_move, req_fire;

   assign rsp_load  = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s2_ready  = !s2_valid_ff || rsp_load;
   assign s1_move   = s1_valid_ff && s2_ready;
   assign req_ready = !s1_valid_ff || s2_ready;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      s1_valid_in  = req_fire ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      s2_valid_in  = s1_move ? 1'b1 : (rsp_load ? 1'b0 : s2_valid_ff);
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // scan pointer, discharge hold and window positions
   logic [KEY_BITS-1:0] ptr_ff, ptr_in;
   logic [DISCH_W-1:0]  hold_ff, hold_in;
   logic [POS_BITS-1:0] pos_ff [KEYS];
   logic [KEYS-1:0]     filled_ff;

   logic                 take;
   logic [POS_BITS-1:0]  cur_pos;
   logic [COUNT_BITS-1:0] sample_cut;
   logic [ACT_W-1:0]     nb_ext, active, ptr_plus;
   logic                 wrap;
   logic [ADDR_BITS-1:0] win_addr;

   assign take       = req_fire && (req_data.command == CMD_SAMPLE) && (hold_ff == '0);
   assign cur_pos    = pos_ff[ptr_ff];
   assign sample_cut = COUNT_BITS'(req_data.sample);
   assign win_addr   = {ptr_ff, cur_pos};

   always_comb begin
      nb_ext   = ACT_W'(num_buttons_ff);
      ptr_plus = ACT_W'(ptr_ff) + ACT_W'(1);
      if (nb_ext == '0) begin
         active = ACT_W'(1);
      end else if (nb_ext > ACT_W'(KEYS)) begin
         active = ACT_W'(KEYS);
      end else begin
         active = nb_ext;
      end
      wrap = (ptr_plus >= active);
   end

   always_comb begin
      hold_in = hold_ff;
      ptr_in  = ptr_ff;
      if (take) begin
         hold_in = discharge_ms_ff;
         ptr_in  = wrap ? '0 : KEY_BITS'(ptr_plus);
      end else if (req_fire && (req_data.command == CMD_TICK) && (hold_ff != '0)) begin
         hold_in = hold_ff - DISCH_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         hold_ff   <= '0;
         filled_ff <= '0;
         for (int i = 0; i < KEYS; i++) begin
            pos_ff[i] <= '0;
         end
      end else begin
         ptr_ff  <= ptr_in;
         hold_ff <= hold_in;
         if (take) begin
            if (cur_pos == POS_BITS'(WINDOW - 1)) begin
               pos_ff[ptr_ff]    <= '0;
               filled_ff[ptr_ff] <= 1'b1;
            end else begin
               pos_ff[ptr_ff] <= cur_pos + POS_BITS'(1);
            end
         end
      end
   end

   // window store, old entry comes back with the stage 1 beat
   logic [COUNT_BITS-1:0] old_raw;

   tks_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (2 ** ADDR_BITS)
   ) u_window (
      .clock   (clock),
      .wr_en   (take),
      .wr_addr (win_addr),
      .wr_data (sample_cut),
      .rd_en   (take),
      .rd_addr (win_addr),
      .rd_data (old_raw)
   );

   // stage 1: running total
   logic                  s1_take_ff, s1_filled_ff, s1_hold_ff;
   logic [KEY_BITS-1:0]   s1_key_ff, s1_next_ff;
   logic [COUNT_BITS-1:0] s1_sample_ff;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_take_ff   <= take;
         s1_key_ff    <= ptr_ff;
         s1_sample_ff <= sample_cut;
         s1_filled_ff <= filled_ff[ptr_ff];
         s1_hold_ff   <= (hold_in != '0);
         s1_next_ff   <= ptr_in;
      end
   end

   logic [TOT_W-1:0]      total_ff [KEYS];
   logic [TOT_W-1:0]      total_in;
   logic [COUNT_BITS-1:0] old_entry;

   assign old_entry = s1_filled_ff ? old_raw : '0;
   assign total_in  = total_ff[s1_key_ff] - TOT_W'(old_entry) + TOT_W'(s1_sample_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < KEYS; i++) begin
            total_ff[i] <= '0;
         end
      end else if (s1_move && s1_take_ff) begin
         total_ff[s1_key_ff] <= total_in;
      end
   end

   // stage 2: average and threshold compare
   logic                  s2_take_ff, s2_hold_ff;
   logic [KEY_BITS-1:0]   s2_key_ff, s2_next_ff;
   logic [COUNT_BITS-1:0] s2_sample_ff;
   logic [TOT_W-1:0]      s2_total_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_take_ff   <= s1_take_ff;
         s2_key_ff    <= s1_key_ff;
         s2_sample_ff <= s1_sample_ff;
         s2_total_ff  <= total_in;
         s2_hold_ff   <= s1_hold_ff;
         s2_next_ff   <= s1_next_ff;
      end
   end

   logic [PROD_W-1:0]     prod;
   logic [COUNT_BITS-1:0] smooth;
   logic [KEY_W-1:0]      thr_sel;
   logic                  touch_now;
   logic [KEYS-1:0]       touched_ff, touched_in;
   logic [MASK_W-1:0]     mask;

   assign prod      = PROD_W'(s2_total_ff) * PROD_W'(RECIP);
   assign smooth    = COUNT_BITS'(prod >> SHIFT);
   assign thr_sel   = KEY_W'(s2_key_ff);
   assign touch_now = CMP_W'(smooth) < CMP_W'(threshold_ff[thr_sel]);

   always_comb begin
      touched_in = touched_ff;
      if (s2_take_ff) begin
         touched_in[s2_key_ff] = touch_now;
      end
   end

   for (genvar i = 0; i < MASK_W; i++) begin : g_mask
      if (i < KEYS) begin : g_key
         assign mask[i] = touched_in[i];
      end else begin : g_none
         assign mask[i] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         touched_ff <= '0;
      end else if (rsp_load) begin
         touched_ff <= touched_in;
      end
   end

   // result register
   rsp_beat_type rsp_data_ff;

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_data_ff.accepted     <= s2_take_ff;
         rsp_data_ff.key_index    <= s2_take_ff ? KEY_W'(s2_key_ff) : '0;
         rsp_data_ff.raw_count    <= s2_take_ff ? SAMPLE_W'(s2_sample_ff) : '0;
         rsp_data_ff.smooth_count <= s2_take_ff ? SAMPLE_W'(smooth) : '0;
         rsp_data_ff.touched_mask <= mask;
         rsp_data_ff.hold_active  <= s2_hold_ff;
         rsp_data_ff.next_key     <= KEY_W'(s2_next_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `TKS_ASSERT_NXT(a_hold_start, clock, reset, take, hold_ff == $past(discharge_ms_ff))
   `TKS_ASSERT_NXT(a_hold_no_rise, clock, reset, !take, hold_ff <= $past(hold_ff))
   `TKS_ASSERT_IMP(a_idle_beat_zero, clock, reset, rsp_valid_ff && !rsp_data_ff.accepted,
                   rsp_data_ff.key_index == '0 && rsp_data_ff.raw_count == '0 &&
                   rsp_data_ff.smooth_count == '0)
   `TKS_ASSERT_NXT(a_s1_stall_holds, clock, reset, s1_valid_ff && !s2_ready,
                   s1_valid_ff && $stable(s1_sample_ff) && (!s1_take_ff || $stable(old_raw)))

endmodule
